// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the median/min-max tracker.
// No dependencies; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: sv/mmt_pkg.sv
// Shared types and constants of the multichannel median min/max tracker.
// No dependencies; imported by every module of the block.
package mmt_pkg;

    // Default configuration.
    localparam int CHANNELS_DEF = 16;
    localparam int WINDOW_DEF   = 8;

    // Calibration reset values.
    localparam logic [12:0] MIN_RESET = 13'd4096;
    localparam logic [11:0] MAX_RESET = 12'd0;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_RESTART = 2'd1,
        OP_LOAD    = 2'd2
    } op_t;

    // Top-level sequencer states.
    typedef enum logic [1:0] {
        T_IDLE,
        T_RANK,
        T_DONE
    } top_state_t;

    // Rank unit states.
    typedef enum logic [1:0] {
        R_IDLE,
        R_CAND,
        R_SCAN,
        R_LAST
    } rank_state_t;

    // Commands from the sequencer to the calibration store.
    typedef struct packed {
        logic        restart;
        logic        load;
        logic        update;
        logic [12:0] load_min;
        logic [11:0] load_max;
        logic [11:0] med;
    } cal_cmd_t;

endpackage

// File: sv/mmt_window_ram.sv
// Sample window memory: one write port, one registered read port.
// Depends on mmt_pkg.
module mmt_window_ram
    import mmt_pkg::*;
#(
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [11:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [11:0]       rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [11:0] mem_reg [DEPTH];
    logic [11:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mmt_rank_unit.sv
// Median search with one shared comparator stepping through window reads.
// Depends on mmt_pkg; reads the window through the RAM read port.
module mmt_rank_unit
    import mmt_pkg::*;
#(
    parameter  int WINDOW = WINDOW_DEF,
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [11:0]       rd_data,
    output logic [SLOT_W-1:0] rd_slot,
    output logic              done,
    output logic [11:0]       median
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0]  MID_POS   = CNT_W'(WINDOW / 2);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    rank_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] ci_reg, ci_next;
    logic [SLOT_W-1:0] j_reg, j_next;
    logic [11:0]       cand_reg, cand_next;
    logic [CNT_W-1:0]  lt_reg, lt_next;
    logic [CNT_W-1:0]  le_reg, le_next;
    logic [11:0]       med_reg, med_next;
    logic [CNT_W-1:0]  lt_sum, le_sum;
    logic              found;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        ci_reg   <= ci_next;
        j_reg    <= j_next;
        cand_reg <= cand_next;
        lt_reg   <= lt_next;
        le_reg   <= le_next;
        med_reg  <= med_next;
    end

    // The shared comparator: counts entries below and at or below the candidate.
    assign lt_sum = lt_reg + CNT_W'(rd_data < cand_reg);
    assign le_sum = le_reg + CNT_W'(rd_data <= cand_reg);
    // The candidate sits at the middle sorted position when it spans it.
    assign found  = (lt_sum <= MID_POS) && (le_sum > MID_POS);

    // Sequencer: one candidate read, then a scan over all window slots.
    always_comb begin
        state_next = state_reg;
        ci_next    = ci_reg;
        j_next     = j_reg;
        cand_next  = cand_reg;
        lt_next    = lt_reg;
        le_next    = le_reg;
        med_next   = med_reg;
        done       = 1'b0;
        rd_slot    = j_reg;
        case (state_reg)
            R_IDLE: begin
                if (start) begin
                    ci_next    = '0;
                    state_next = R_CAND;
                end
            end
            R_CAND: begin
                rd_slot    = ci_reg;
                j_next     = '0;
                lt_next    = '0;
                le_next    = '0;
                state_next = R_SCAN;
            end
            R_SCAN: begin
                // The first data word back is the candidate itself.
                if (j_reg == '0) begin
                    cand_next = rd_data;
                end else begin
                    lt_next = lt_sum;
                    le_next = le_sum;
                end
                if (j_reg == LAST_SLOT) begin
                    state_next = R_LAST;
                end else begin
                    j_next = j_reg + SLOT_W'(1);
                end
            end
            R_LAST: begin
                if (found || (ci_reg == LAST_SLOT)) begin
                    med_next   = cand_reg;
                    done       = 1'b1;
                    state_next = R_IDLE;
                end else begin
                    ci_next    = ci_reg + SLOT_W'(1);
                    state_next = R_CAND;
                end
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

    assign median = med_reg;

endmodule

// File: sv/mmt_cal_store.sv
// Per-channel running minimum and maximum of medians, with restart and load.
// Depends on mmt_pkg for the command struct and reset values.
module mmt_cal_store
    import mmt_pkg::*;
#(
    parameter  int CHANNELS = CHANNELS_DEF,
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  cal_cmd_t        cmd,
    input  logic [CH_W-1:0] ch,
    output logic [12:0]     upd_min,
    output logic [11:0]     upd_max
);

    logic [12:0] min_reg [CHANNELS];
    logic [11:0] max_reg [CHANNELS];
    logic [12:0] cur_min;
    logic [11:0] cur_max;
    logic [12:0] sat_min;

    // Current values of the addressed channel, merged with the new median.
    assign cur_min = min_reg[ch];
    assign cur_max = max_reg[ch];
    assign upd_min = (cur_min > {1'b0, cmd.med}) ? {1'b0, cmd.med} : cur_min;
    assign upd_max = (cur_max < cmd.med) ? cmd.med : cur_max;

    // A loaded minimum never exceeds the reset value.
    assign sat_min = (cmd.load_min > MIN_RESET) ? MIN_RESET : cmd.load_min;

    // Storage: reset and restart clear every channel at once.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            for (int i = 0; i < CHANNELS; i++) begin
                min_reg[i] <= MIN_RESET;
                max_reg[i] <= MAX_RESET;
            end
        end else if (cmd.load) begin
            min_reg[ch] <= sat_min;
            max_reg[ch] <= cmd.load_max;
        end else if (cmd.update) begin
            min_reg[ch] <= upd_min;
            max_reg[ch] <= upd_max;
        end
    end

endmodule

// File: sv/multichannel_median_minmax_tracker.sv
// Multichannel median tracker: a sample request on a non-full window stores into
// the current window slot of its channel; on a full window it ranks the channel's
// WINDOW stored values with one comparator, taking each slot in turn as a
// candidate and reading all slots from the window RAM, and emits channel, median
// and the updated running minimum and maximum. For each of the c candidates tried
// (1 to WINDOW) the candidate is read, then every slot is scanned, the single RAM
// read port feeding the comparator one value a cycle; then the candidate is checked.
// The result sits in an output register, so the next request is taken while
// it waits; a second result waits until the first has been taken.
`include "assert_macros.svh"
module multichannel_median_minmax_tracker
    import mmt_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [3:0]  s_channel,
    input  logic [11:0] s_sample,
    input  logic        s_last_in_frame,
    input  logic [12:0] s_min_value,
    input  logic [11:0] s_max_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_channel_out,
    output logic [11:0] m_median,
    output logic [12:0] m_min_seen,
    output logic [11:0] m_max_seen
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = SLOT_W + CH_W;

    top_state_t        state_reg, state_next;
    logic [4:0]        fc_reg, fc_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [11:0]       smp_reg, smp_next;
    logic              m_valid_reg, m_valid_next;
    logic [3:0]        m_channel_out_reg, m_channel_out_next;
    logic [11:0]       m_median_reg, m_median_next;
    logic [12:0]       m_min_seen_reg, m_min_seen_next;
    logic [11:0]       m_max_seen_reg, m_max_seen_next;

    logic              accept;
    logic              ch_ok;
    logic              full;
    logic              is_sample;
    logic              out_free;
    logic [CH_W-1:0]   ch_in;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [11:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [11:0]       ram_rdata;
    logic              rank_start;
    logic              rank_done;
    logic [SLOT_W-1:0] rank_slot;
    logic [11:0]       rank_median;
    cal_cmd_t          cal_cmd;
    logic [CH_W-1:0]   cal_ch;
    logic [12:0]       upd_min;
    logic [11:0]       upd_max;
    logic              out_bracket_ok;

    // Request decode.
    assign accept    = s_valid && s_ready;
    assign ch_in     = CH_W'(s_channel);
    assign ch_ok     = {2'b00, s_channel} < 6'(CHANNELS);
    assign full      = fc_reg >= 5'(WINDOW);
    assign is_sample = accept && (s_op == OP_SAMPLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == T_IDLE);

    // Window RAM: samples written on request or after the median is out.
    assign ram_we    = (is_sample && ch_ok && !full) ||
                       ((state_reg == T_DONE) && out_free);
    assign ram_waddr = (state_reg == T_DONE) ? {SLOT_W'(0), ch_reg}
                                             : {fc_reg[SLOT_W-1:0], ch_in};
    assign ram_wdata = (state_reg == T_DONE) ? smp_reg : s_sample;
    assign ram_raddr = {rank_slot, ch_reg};

    mmt_window_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Median search over the addressed channel's window.
    assign rank_start = is_sample && ch_ok && full;

    mmt_rank_unit #(
        .WINDOW (WINDOW)
    ) u_rank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rank_start),
        .rd_data (ram_rdata),
        .rd_slot (rank_slot),
        .done    (rank_done),
        .median  (rank_median)
    );

    // Calibration store commands.
    always_comb begin
        cal_cmd.restart  = accept && (s_op == OP_RESTART);
        cal_cmd.load     = accept && (s_op == OP_LOAD) && ch_ok;
        cal_cmd.update   = (state_reg == T_DONE) && out_free;
        cal_cmd.load_min = s_min_value;
        cal_cmd.load_max = s_max_value;
        cal_cmd.med      = rank_median;
    end
    assign cal_ch = (state_reg == T_IDLE) ? ch_in : ch_reg;

    mmt_cal_store #(
        .CHANNELS (CHANNELS)
    ) u_cal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cal_cmd),
        .ch      (cal_ch),
        .upd_min (upd_min),
        .upd_max (upd_max)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            fc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fc_reg      <= fc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ch_reg            <= ch_next;
        smp_reg           <= smp_next;
        m_channel_out_reg <= m_channel_out_next;
        m_median_reg      <= m_median_next;
        m_min_seen_reg    <= m_min_seen_next;
        m_max_seen_reg    <= m_max_seen_next;
    end

    // Sequencer, frame counter and output register.
    always_comb begin
        state_next         = state_reg;
        fc_next            = fc_reg;
        ch_next            = ch_reg;
        smp_next           = smp_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_channel_out_next = m_channel_out_reg;
        m_median_next      = m_median_reg;
        m_min_seen_next    = m_min_seen_reg;
        m_max_seen_next    = m_max_seen_reg;
        case (state_reg)
            T_IDLE: begin
                if (cal_cmd.restart) begin
                    fc_next = '0;
                end
                if (is_sample && s_last_in_frame) begin
                    fc_next = full ? 5'd1 : fc_reg + 5'd1;
                end
                if (rank_start) begin
                    ch_next    = ch_in;
                    smp_next   = s_sample;
                    state_next = T_RANK;
                end
            end
            T_RANK: begin
                if (rank_done) begin
                    state_next = T_DONE;
                end
            end
            T_DONE: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_channel_out_next = 4'(ch_reg);
                    m_median_next      = rank_median;
                    m_min_seen_next    = upd_min;
                    m_max_seen_next    = upd_max;
                    state_next         = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_out_reg;
    assign m_median      = m_median_reg;
    assign m_min_seen    = m_min_seen_reg;
    assign m_max_seen    = m_max_seen_reg;

    // The held result's min and max bracket its median.
    assign out_bracket_ok = (m_min_seen_reg <= {1'b0, m_median_reg}) &&
                            (m_max_seen_reg >= m_median_reg);

    // A result's min and max bracket its median.
    `ASSERT_IMPLY(a_out_bracket, aclk, aresetn, m_valid_reg, out_bracket_ok)
    // A new result only comes out of the completion state.
    `ASSERT_IMPLY(a_out_source, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == T_DONE))
    // The rank unit finishes only while the sequencer waits for it.
    `ASSERT_IMPLY(a_rank_done, aclk, aresetn, rank_done, state_reg == T_RANK)
    // Starting a search moves the sequencer into the ranking state.
    `ASSERT_NEXT(a_rank_start, aclk, aresetn, rank_start, state_reg == T_RANK)

endmodule
